@@ rtl/core/gbfp_pkg.sv @@
`default_nettype none
package gbfp_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] word_type;
   typedef logic [1:0]  status_type;
   typedef logic        kind_type;

   localparam byte_type SYNC_FIRST  = 8'hB5;
   localparam byte_type SYNC_SECOND = 8'h62;

   localparam word_type MAX_LEN_RESET = 16'd512;

   localparam kind_type KIND_PAYLOAD = 1'b0;
   localparam kind_type KIND_VERDICT = 1'b1;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_BAD_SUM = 2'd1;
   localparam status_type STATUS_TOO_LONG = 2'd2;

   typedef enum logic [8:0] {
      PH_HUNT    = 9'b000000001,
      PH_SYNC2   = 9'b000000010,
      PH_CLASS   = 9'b000000100,
      PH_ID      = 9'b000001000,
      PH_LEN_LO  = 9'b000010000,
      PH_LEN_HI  = 9'b000100000,
      PH_PAYLOAD = 9'b001000000,
      PH_CK_A    = 9'b010000000,
      PH_CK_B    = 9'b100000000
   } phase_type;

endpackage
`default_nettype wire

@@ rtl/core/gbfp_req_if.sv @@
`default_nettype none
interface gbfp_req_if;
   logic                valid;
   logic                ready;
   gbfp_pkg::byte_type  data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/core/gbfp_rsp_if.sv @@
`default_nettype none
interface gbfp_rsp_if;
   logic                  valid;
   logic                  ready;
   gbfp_pkg::kind_type    kind;
   gbfp_pkg::byte_type    payload_byte;
   gbfp_pkg::word_type    payload_index;
   gbfp_pkg::byte_type    msg_class;
   gbfp_pkg::byte_type    msg_id;
   gbfp_pkg::word_type    payload_length;
   gbfp_pkg::status_type  status;

   modport source (output valid, output kind, output payload_byte, output payload_index,
                   output msg_class, output msg_id, output payload_length,
                   output status, input ready);
   modport sink (input valid, input kind, input payload_byte, input payload_index,
                 input msg_class, input msg_id, input payload_length,
                 input status, output ready);
endinterface
`default_nettype wire

@@ rtl/core/gnss_binary_frame_parser.sv @@
// Binary GNSS frame parser with 8-bit Fletcher check.
// req_bus carries one raw stream byte per beat. The parser hunts for the
// sync pair B5 62, captures class, id and the little-endian payload length,
// then emits one rsp_bus beat per payload byte (kind 0, with its index) and
// one verdict beat (kind 1): at frame end ok or checksum mismatch, or after the
// length bytes a length above the maximum payload length. No other beats.
// Each accepted byte is handled in the cycle it is accepted; its result, if
// any, sits in the output register and is valid on the next cycle. The
// parser takes one byte per cycle while the receiver keeps taking results.
// req_bus.ready is high while the output register is empty or being taken
// in the same cycle; when the receiver stalls with a result waiting, input
// stops until that beat is taken. No result is lost or dropped.
// csr_wr_en writes the maximum payload length; write it only while idle.
// Synchronous reset returns the parser to hunting, empties the output
// register and sets the maximum payload length to 512.
`default_nettype none
module gnss_binary_frame_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   gbfp_req_if.sink                  req_bus,
   gbfp_rsp_if.source                rsp_bus,
   input  wire logic                 csr_wr_en,
   input  wire gbfp_pkg::word_type   csr_wr_data
);
   import gbfp_pkg::*;

   phase_type  phase_ff, phase_in;
   byte_type   class_ff, class_in;
   byte_type   id_ff, id_in;
   word_type   length_ff, length_in;
   word_type   count_ff, count_in;
   byte_type   sum_a_ff, sum_a_in;
   byte_type   sum_b_ff, sum_b_in;
   byte_type   check_a_ff, check_a_in;
   word_type   max_len_ff;

   logic       out_valid_ff, out_valid_in;
   kind_type   out_kind_ff, out_kind_in;
   byte_type   out_byte_ff, out_byte_in;
   word_type   out_index_ff, out_index_in;
   byte_type   out_class_ff, out_class_in;
   byte_type   out_id_ff, out_id_in;
   word_type   out_length_ff, out_length_in;
   status_type out_status_ff, out_status_in;

   logic       accept;
   logic       emit;
   byte_type   b;
   byte_type   add_a;
   byte_type   add_b;
   word_type   count_next;

   assign req_bus.ready = !out_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.data_byte;
   assign add_a         = sum_a_ff + b;
   assign add_b         = sum_b_ff + add_a;
   assign count_next    = count_ff + 16'd1;

   always_comb begin
      phase_in     = phase_ff;
      class_in     = class_ff;
      id_in        = id_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      check_a_in   = check_a_ff;
      emit         = 1'b0;
      out_kind_in  = KIND_VERDICT;
      out_byte_in  = '0;
      out_index_in = '0;
      out_status_in = STATUS_OK;
      case (phase_ff)
         PH_SYNC2: begin
            sum_a_in = '0;
            sum_b_in = '0;
            phase_in = (b == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
         end
         PH_CLASS: begin
            class_in = b;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = b;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {8'd0, b};
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = {b, length_ff[7:0]};
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            count_in  = '0;
            if (length_in > max_len_ff) begin
               emit          = 1'b1;
               out_status_in = STATUS_TOO_LONG;
               phase_in      = PH_HUNT;
            end else if (length_in == '0) begin
               phase_in = PH_CK_A;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_a_in     = add_a;
            sum_b_in     = add_b;
            emit         = 1'b1;
            out_kind_in  = KIND_PAYLOAD;
            out_byte_in  = b;
            out_index_in = count_ff;
            count_in     = count_next;
            if (count_next >= length_ff) begin
               phase_in = PH_CK_A;
            end
         end
         PH_CK_A: begin
            check_a_in = b;
            phase_in   = PH_CK_B;
         end
         PH_CK_B: begin
            emit          = 1'b1;
            out_status_in = ((check_a_ff == sum_a_ff) && (b == sum_b_ff)) ?
                            STATUS_OK : STATUS_BAD_SUM;
            phase_in      = PH_HUNT;
         end
         default: begin
            // hunting, and any unexpected phase code
            phase_in = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
         end
      endcase
      out_class_in  = class_in;
      out_id_in     = id_in;
      out_length_in = length_in;
      if (accept) begin
         out_valid_in = emit;
      end else begin
         out_valid_in = out_valid_ff && !rsp_bus.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         out_valid_ff <= 1'b0;
         max_len_ff   <= MAX_LEN_RESET;
      end else begin
         out_valid_ff <= out_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
         end
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         class_ff   <= class_in;
         id_ff      <= id_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         sum_a_ff   <= sum_a_in;
         sum_b_ff   <= sum_b_in;
         check_a_ff <= check_a_in;
      end
      if (accept && emit) begin
         out_kind_ff   <= out_kind_in;
         out_byte_ff   <= out_byte_in;
         out_index_ff  <= out_index_in;
         out_class_ff  <= out_class_in;
         out_id_ff     <= out_id_in;
         out_length_ff <= out_length_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.kind           = out_kind_ff;
   assign rsp_bus.payload_byte   = out_byte_ff;
   assign rsp_bus.payload_index  = out_index_ff;
   assign rsp_bus.msg_class      = out_class_ff;
   assign rsp_bus.msg_id         = out_id_ff;
   assign rsp_bus.payload_length = out_length_ff;
   assign rsp_bus.status         = out_status_ff;

endmodule
`default_nettype wire
